// File: hdl/lslc_pkg.sv
// Package for the largest single-linkage cluster block.
// Holds item and point structs, controller states, datapath commands and status.
// No dependencies.
package lslc_pkg;

    localparam int COORD_W        = 16;
    localparam int EXTRA_W        = 16;
    localparam int DIST_W         = 36;
    localparam int MAX_POINTS_DEF = 64;

    localparam logic [DIST_W-1:0] DIST_INF   = '1;
    localparam logic [DIST_W-1:0] DIST_SAT   = DIST_INF - 1'b1;
    localparam logic [DIST_W-1:0] THR_RESET  = DIST_W'(65536);

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic signed [EXTRA_W-1:0] extra_value;
        logic                      last_point;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic signed [EXTRA_W-1:0] out_extra;
        logic                      is_empty;
        logic                      last_out;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [EXTRA_W-1:0] e;
    } t_point;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_B_ROW, ST_B_LATCH, ST_B_RD, ST_B_MUL, ST_B_ACC, ST_B_END,
        ST_M_INIT, ST_M_RD, ST_M_CMP, ST_M_CHK,
        ST_M_SZA, ST_M_SZB, ST_M_SZC, ST_M_SZD, ST_M_NA,
        ST_M_LRD, ST_M_LWR,
        ST_M_JR, ST_M_JE, ST_M_JW2, ST_M_JW3, ST_M_JW4, ST_M_FIN,
        ST_O_INIT, ST_O_RD, ST_O_USE, ST_O_LAST
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD,
        OP_B_ROW, OP_B_LATCH, OP_B_RD, OP_B_MUL, OP_B_ACC, OP_B_END,
        OP_M_INIT, OP_M_RD, OP_M_CMP,
        OP_M_SZA, OP_M_SZB, OP_M_SZC, OP_M_SZD, OP_M_NA,
        OP_M_LRD, OP_M_LWR,
        OP_M_JR, OP_M_JE, OP_M_JW2, OP_M_JW3, OP_M_JW4, OP_M_FIN,
        OP_O_INIT, OP_O_RD, OP_O_USE, OP_O_LAST
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic row_last;
        logic col_last;
        logic stop;
        logic best_zero;
    } t_dp_status;

endpackage

// File: hdl/lslc_ctrl.sv
// Controller state machine for the largest single-linkage cluster block.
// Sequences load, matrix build, merge and output sweeps; depends on lslc_pkg.
module lslc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                i_last_point,
    input  lslc_pkg::t_dp_status i_status,
    output lslc_pkg::t_dp_cmd   o_cmd,
    output logic                busy
);
    import lslc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        busy     = 1'b1;
        unique case (r_state)
            ST_LOAD: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.op = OP_LOAD;
                    if (i_last_point) n_state = ST_B_ROW;
                end
            end
            ST_B_ROW: begin
                o_cmd.op = OP_B_ROW;
                n_state  = ST_B_LATCH;
            end
            ST_B_LATCH: begin
                o_cmd.op = OP_B_LATCH;
                n_state  = ST_B_RD;
            end
            ST_B_RD: begin
                o_cmd.op = OP_B_RD;
                n_state  = ST_B_MUL;
            end
            ST_B_MUL: begin
                o_cmd.op = OP_B_MUL;
                n_state  = ST_B_ACC;
            end
            ST_B_ACC: begin
                o_cmd.op = OP_B_ACC;
                n_state  = i_status.col_last ? ST_B_END : ST_B_RD;
            end
            ST_B_END: begin
                o_cmd.op = OP_B_END;
                n_state  = i_status.row_last ? ST_M_INIT : ST_B_ROW;
            end
            ST_M_INIT: begin
                o_cmd.op = OP_M_INIT;
                n_state  = ST_M_RD;
            end
            ST_M_RD: begin
                o_cmd.op = OP_M_RD;
                n_state  = ST_M_CMP;
            end
            ST_M_CMP: begin
                o_cmd.op = OP_M_CMP;
                n_state  = i_status.row_last ? ST_M_CHK : ST_M_RD;
            end
            ST_M_CHK: begin
                n_state = i_status.stop ? ST_O_INIT : ST_M_SZA;
            end
            ST_M_SZA: begin
                o_cmd.op = OP_M_SZA;
                n_state  = ST_M_SZB;
            end
            ST_M_SZB: begin
                o_cmd.op = OP_M_SZB;
                n_state  = ST_M_SZC;
            end
            ST_M_SZC: begin
                o_cmd.op = OP_M_SZC;
                n_state  = ST_M_SZD;
            end
            ST_M_SZD: begin
                o_cmd.op = OP_M_SZD;
                n_state  = ST_M_NA;
            end
            ST_M_NA: begin
                o_cmd.op = OP_M_NA;
                n_state  = ST_M_LRD;
            end
            ST_M_LRD: begin
                o_cmd.op = OP_M_LRD;
                n_state  = ST_M_LWR;
            end
            ST_M_LWR: begin
                o_cmd.op = OP_M_LWR;
                n_state  = i_status.row_last ? ST_M_JR : ST_M_LRD;
            end
            ST_M_JR: begin
                o_cmd.op = OP_M_JR;
                n_state  = ST_M_JE;
            end
            ST_M_JE: begin
                o_cmd.op = OP_M_JE;
                n_state  = ST_M_JW2;
            end
            ST_M_JW2: begin
                o_cmd.op = OP_M_JW2;
                n_state  = ST_M_JW3;
            end
            ST_M_JW3: begin
                o_cmd.op = OP_M_JW3;
                n_state  = ST_M_JW4;
            end
            ST_M_JW4: begin
                o_cmd.op = OP_M_JW4;
                n_state  = i_status.col_last ? ST_M_FIN : ST_M_JR;
            end
            ST_M_FIN: begin
                o_cmd.op = OP_M_FIN;
                n_state  = ST_M_INIT;
            end
            ST_O_INIT: begin
                o_cmd.op = OP_O_INIT;
                n_state  = i_status.best_zero ? ST_LOAD : ST_O_RD;
            end
            ST_O_RD: begin
                o_cmd.op = OP_O_RD;
                n_state  = ST_O_USE;
            end
            ST_O_USE: begin
                o_cmd.op = OP_O_USE;
                n_state  = i_status.row_last ? ST_O_LAST : ST_O_RD;
            end
            ST_O_LAST: begin
                o_cmd.op = OP_O_LAST;
                n_state  = ST_LOAD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

// File: hdl/lslc_dp.sv
// Datapath for the largest single-linkage cluster block.
// Point, distance, nearest, label and size memories, distance unit and output register.
// Depends on lslc_pkg; driven by lslc_ctrl commands.
module lslc_dp #(
    parameter int MAX_POINTS = lslc_pkg::MAX_POINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lslc_pkg::t_dp_cmd            i_cmd,
    input  lslc_pkg::t_in_item           i_item,
    input  logic                         i_cfg_we,
    input  logic [lslc_pkg::DIST_W-1:0]  i_cfg_wdata,
    output lslc_pkg::t_dp_status         o_status,
    output lslc_pkg::t_out_item          o_result,
    output logic                         o_result_valid
);
    import lslc_pkg::*;

    localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int DD   = 1 << (2 * IW);
    localparam int SQ_W = 2 * COORD_W + 2;
    localparam int SM_W = DIST_W + 2;

    // storage
    t_point            m_pt   [MAX_POINTS];
    logic [DIST_W-1:0] m_dist [DD];
    logic [DIST_W-1:0] m_nd   [MAX_POINTS];
    logic [IW-1:0]     m_nidx [MAX_POINTS];
    logic [IW-1:0]     m_lab  [MAX_POINTS];
    logic [CW-1:0]     m_sz   [MAX_POINTS];

    t_point            r_pt_rd;
    logic [DIST_W-1:0] r_da_rd, r_db_rd, r_nd_rd;
    logic [IW-1:0]     r_nidx_rd, r_lab_rd;
    logic [CW-1:0]     r_sz_rd;

    logic [DIST_W-1:0] r_thr;
    logic [CW-1:0]     r_count, r_best_size, r_sa, r_newsz;
    logic [IW-1:0]     r_i, r_j, r_a, r_b, r_na, r_nir;
    logic [DIST_W-1:0] r_best, r_nda, r_ndr, r_dbv;
    logic              r_found, r_snap, r_lt, r_pv;
    logic [MAX_POINTS-1:0] r_bm;
    t_point            r_pi, r_pend;
    logic [SQ_W-1:0]   r_sqx, r_sqy, r_sqz;
    t_out_item         r_out;
    logic              r_out_v;

    // memory ports
    logic                pt_we;
    logic [IW-1:0]       pt_raddr;
    logic                dist_we;
    logic [2*IW-1:0]     dist_waddr;
    logic [DIST_W-1:0]   dist_wdata;
    logic                nd_we;
    logic [IW-1:0]       nd_waddr;
    logic [DIST_W-1:0]   nd_wdata;
    logic                nidx_we;
    logic [IW-1:0]       nidx_waddr, nidx_wdata, nidx_raddr;
    logic                lab_we;
    logic [IW-1:0]       lab_waddr, lab_wdata;
    logic                sz_we;
    logic [IW-1:0]       sz_waddr, sz_raddr;
    logic [CW-1:0]       sz_wdata;

    // distance unit
    logic signed [COORD_W:0]   dx, dy, dz;
    logic signed [SQ_W-1:0]    px, py, pz;
    logic [SM_W-1:0]           sum;
    logic [DIST_W-1:0]         dist_new;

    // merge helpers
    logic              je_lt, je_upd;
    logic [DIST_W-1:0] je_val;
    logic [IW-1:0]     lab_new;
    logic [CW-1:0]     sz_sum;

    assign dx = (COORD_W+1)'(r_pi.x) - (COORD_W+1)'(r_pt_rd.x);
    assign dy = (COORD_W+1)'(r_pi.y) - (COORD_W+1)'(r_pt_rd.y);
    assign dz = (COORD_W+1)'(r_pi.z) - (COORD_W+1)'(r_pt_rd.z);
    assign px = dx * dx;
    assign py = dy * dy;
    assign pz = dz * dz;
    assign sum = SM_W'(r_sqx) + SM_W'(r_sqy) + SM_W'(r_sqz);

    always_comb begin
        if (r_i == r_j) begin
            dist_new = DIST_INF;
        end else if (sum > SM_W'(DIST_SAT)) begin
            dist_new = DIST_SAT;
        end else begin
            dist_new = sum[DIST_W-1:0];
        end
    end

    assign je_lt   = (r_j != r_a) && (r_db_rd < r_da_rd);
    assign je_val  = je_lt ? r_db_rd : r_da_rd;
    assign je_upd  = (r_j != r_a) && (r_j != r_b) && (je_val < r_nda);
    assign lab_new = (r_lab_rd == r_b) ? r_a : r_lab_rd;
    assign sz_sum  = r_sa + r_sz_rd;

    assign o_status.row_last  = (CW'(r_i) + CW'(1)) == r_count;
    assign o_status.col_last  = (CW'(r_j) + CW'(1)) == r_count;
    assign o_status.stop      = !r_found || (r_best >= r_thr) || (r_a == r_b)
                                || (CW'(r_b) >= r_count);
    assign o_status.best_zero = (r_best_size == '0);

    assign o_result       = r_out;
    assign o_result_valid = r_out_v;

    always_comb begin
        pt_we      = 1'b0;
        pt_raddr   = r_i;
        dist_we    = 1'b0;
        dist_waddr = {r_a, r_j};
        dist_wdata = DIST_INF;
        nd_we      = 1'b0;
        nd_waddr   = r_i;
        nd_wdata   = r_ndr;
        nidx_we    = 1'b0;
        nidx_waddr = r_i;
        nidx_wdata = r_nir;
        nidx_raddr = r_i;
        lab_we     = 1'b0;
        lab_waddr  = r_i;
        lab_wdata  = r_i;
        sz_we      = 1'b0;
        sz_waddr   = r_a;
        sz_wdata   = sz_sum;
        sz_raddr   = r_b;
        case (i_cmd.op)
            OP_LOAD: begin
                pt_we = (r_count < CW'(MAX_POINTS));
            end
            OP_B_RD: begin
                pt_raddr = r_j;
            end
            OP_B_ACC: begin
                dist_we    = 1'b1;
                dist_waddr = {r_i, r_j};
                dist_wdata = dist_new;
            end
            OP_B_END: begin
                nd_we    = 1'b1;
                nidx_we  = 1'b1;
                lab_we   = 1'b1;
                sz_we    = 1'b1;
                sz_waddr = r_i;
                sz_wdata = CW'(1);
            end
            OP_M_SZA: begin
                sz_raddr = r_a;
            end
            OP_M_SZC: begin
                sz_we = 1'b1;
            end
            OP_M_SZD: begin
                sz_we      = 1'b1;
                sz_waddr   = r_b;
                sz_wdata   = '0;
                nd_we      = 1'b1;
                nd_waddr   = r_b;
                nd_wdata   = DIST_INF;
                nidx_raddr = r_a;
            end
            OP_M_LWR: begin
                lab_we    = (r_lab_rd == r_b);
                lab_wdata = r_a;
            end
            OP_M_JR: begin
                nidx_raddr = r_j;
            end
            OP_M_JE: begin
                dist_we    = je_lt;
                dist_wdata = r_db_rd;
                nidx_we    = (r_j != r_a) && (r_nidx_rd == r_b);
                nidx_waddr = r_j;
                nidx_wdata = r_a;
            end
            OP_M_JW2: begin
                dist_we    = r_lt;
                dist_waddr = {r_j, r_a};
                dist_wdata = r_dbv;
            end
            OP_M_JW3: begin
                dist_we    = 1'b1;
                dist_waddr = {r_b, r_j};
            end
            OP_M_JW4: begin
                dist_we    = 1'b1;
                dist_waddr = {r_j, r_b};
            end
            OP_M_FIN: begin
                nd_we      = 1'b1;
                nd_waddr   = r_a;
                nd_wdata   = r_nda;
                nidx_we    = 1'b1;
                nidx_waddr = r_a;
                nidx_wdata = r_na;
            end
            default: begin
            end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            m_pt[r_count[IW-1:0]] <= '{x: i_item.coord_x, y: i_item.coord_y,
                                       z: i_item.coord_z, e: i_item.extra_value};
        end
        r_pt_rd <= m_pt[pt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (dist_we) m_dist[dist_waddr] <= dist_wdata;
        r_da_rd <= m_dist[{r_a, r_j}];
        r_db_rd <= m_dist[{r_b, r_j}];
    end

    always_ff @(posedge i_clk) begin
        if (nd_we) m_nd[nd_waddr] <= nd_wdata;
        r_nd_rd <= m_nd[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (nidx_we) m_nidx[nidx_waddr] <= nidx_wdata;
        r_nidx_rd <= m_nidx[nidx_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (lab_we) m_lab[lab_waddr] <= lab_wdata;
        r_lab_rd <= m_lab[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (sz_we) m_sz[sz_waddr] <= sz_wdata;
        r_sz_rd <= m_sz[sz_raddr];
    end

    // payload and work registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_B_ROW: begin
                r_j   <= '0;
                r_ndr <= DIST_INF;
                r_nir <= '0;
            end
            OP_B_LATCH: r_pi <= r_pt_rd;
            OP_B_MUL: begin
                r_sqx <= $unsigned(px);
                r_sqy <= $unsigned(py);
                r_sqz <= $unsigned(pz);
            end
            OP_B_ACC: begin
                if (dist_new < r_ndr) begin
                    r_ndr <= dist_new;
                    r_nir <= r_j;
                end
                r_j <= r_j + 1'b1;
            end
            OP_M_INIT: begin
                r_best  <= DIST_INF;
                r_found <= 1'b0;
                r_a     <= '0;
                r_b     <= '0;
            end
            OP_M_CMP: begin
                if (r_nd_rd < r_best) begin
                    r_best  <= r_nd_rd;
                    r_a     <= r_i;
                    r_b     <= r_nidx_rd;
                    r_found <= 1'b1;
                end
            end
            OP_M_SZB: r_sa <= r_sz_rd;
            OP_M_SZC: begin
                r_newsz <= sz_sum;
                r_snap  <= (sz_sum > r_best_size);
            end
            OP_M_NA: begin
                r_na  <= r_nidx_rd;
                r_nda <= DIST_INF;
                r_j   <= '0;
            end
            OP_M_JE: begin
                r_lt  <= je_lt;
                r_dbv <= r_db_rd;
                if (je_upd) begin
                    r_nda <= je_val;
                    r_na  <= r_j;
                end else if ((r_j == r_a) && (r_na == r_b)) begin
                    r_na <= r_a;
                end
            end
            OP_M_JW4: r_j <= r_j + 1'b1;
            OP_O_USE: begin
                if (r_bm[r_i]) r_pend <= r_pt_rd;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RESET;
            r_count     <= '0;
            r_best_size <= '0;
            r_bm        <= '0;
            r_i         <= '0;
            r_pv        <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            r_out_v <= 1'b0;
            if (i_cfg_we) r_thr <= i_cfg_wdata;
            case (i_cmd.op)
                OP_LOAD: begin
                    if (pt_we) r_count <= r_count + 1'b1;
                    if (i_item.last_point) begin
                        r_best_size <= '0;
                        r_bm        <= '0;
                        r_i         <= '0;
                    end
                end
                OP_B_END, OP_M_CMP, OP_M_LWR: begin
                    r_i <= r_i + 1'b1;
                    if (i_cmd.op == OP_M_LWR && r_snap) r_bm[r_i] <= (lab_new == r_a);
                end
                OP_M_INIT: r_i <= '0;
                OP_M_SZD: begin
                    r_i <= '0;
                    if (r_snap) r_best_size <= r_newsz;
                end
                OP_O_INIT: begin
                    r_i  <= '0;
                    r_pv <= 1'b0;
                    if (r_best_size == '0) begin
                        r_out   <= '{default: '0, is_empty: 1'b1, last_out: 1'b1};
                        r_out_v <= 1'b1;
                        r_count <= '0;
                    end
                end
                OP_O_USE: begin
                    r_i <= r_i + 1'b1;
                    if (r_bm[r_i]) begin
                        r_pv <= 1'b1;
                        if (r_pv) begin
                            r_out   <= '{out_x: r_pend.x, out_y: r_pend.y,
                                         out_z: r_pend.z, out_extra: r_pend.e,
                                         is_empty: 1'b0, last_out: 1'b0};
                            r_out_v <= 1'b1;
                        end
                    end
                end
                OP_O_LAST: begin
                    r_out       <= '{out_x: r_pend.x, out_y: r_pend.y,
                                     out_z: r_pend.z, out_extra: r_pend.e,
                                     is_empty: 1'b0, last_out: 1'b1};
                    r_out_v     <= 1'b1;
                    r_count     <= '0;
                    r_best_size <= '0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hdl/largest_single_linkage_cluster.sv
// Top level of the largest single-linkage cluster block.
// Joins lslc_ctrl and lslc_dp; depends on lslc_pkg.
//
//  channel   signals                          handshake
//  item in   i_item (t_in_item)               start high while busy low
//  result    o_result (t_out_item)            o_result_valid, one cycle
//  config    i_cfg_wdata (36 b)               i_cfg_we
//
// A point without last_point is taken while busy stays low. The last point starts clustering of n
// points: a matrix build, then per merge sweeps over the distance memory and nearest
// tables, a closing scan, and an output sweep; each result shows in the cycle after its
// sweep step. busy is high from the last point until the final result is on the ports.
// Reset is synchronous and leaves the point set empty with the threshold at 65536.
// Results cannot be stalled.
module largest_single_linkage_cluster #(
    parameter int MAX_POINTS = lslc_pkg::MAX_POINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  lslc_pkg::t_in_item           i_item,
    input  logic                         i_cfg_we,
    input  logic [lslc_pkg::DIST_W-1:0]  i_cfg_wdata,
    output lslc_pkg::t_out_item          o_result,
    output logic                         o_result_valid
);
    import lslc_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    lslc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_last_point (i_item.last_point),
        .i_status     (status),
        .o_cmd        (cmd),
        .busy         (busy)
    );

    lslc_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_status       (status),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule
